/* src/stq_pkg.sv */
// Shared types and constants for the sorted timer queue.
// No dependencies; used by sorted_timer_queue_top.
`default_nettype none

package stq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int KIND_W       = 2;
  localparam int ID_W         = 8;
  localparam int FIELD_TIME_W = 32;
  localparam int STATUS_W     = 2;

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PUT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* src/sorted_timer_queue_top.sv */
// Sorted timer queue: top level with entry storage and the walk sequencer.
// Depends on stq_pkg.
`default_nettype none

// A queue of up to DEPTH timers (8-bit id, absolute deadline) kept in deadline
// order in a single-port-read, single-port-write memory, entry 0 the earliest.
// One item is worked at a time; in_stall stays high from acceptance until the
// result is loaded into the output register. Every entry visit is a registered
// memory read (read state), then compare and write back (eval state). An add
// walks, puts and loads the result; a delete or tick walks and loads the result.
// A full add, a delete/tick on an empty queue, or kind 3 goes straight to the
// result load. The sequencer then returns to idle before it takes the next
// item. A result still stalled in the output register holds the next one in
// the done state until the output register frees up.
// Add: walk from the top entry down, shifting entries with a deadline equal or
// later up by one, then drop the new timer into the gap, so a new timer lands
// in front of any with the same deadline. Delete: walk up from entry 0, find
// the first matching id and pull all later entries down by one. Tick: same
// walk, where only entry 0 can match and it matches when its deadline is at or
// before the tick time. Unmatched deletes report not-found, adds to a full
// queue report full; kind 3 is a no-op that still returns one result item.
// Deadlines are plain unsigned TIME_BITS values, no wrap handling. Storage is
// not cleared at reset: only entries below the pending count are ever read.
module sorted_timer_queue_top #(
  parameter int DEPTH     = stq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input item channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [stq_pkg::KIND_W-1:0]     kind,
  input  wire logic [stq_pkg::ID_W-1:0]       entry_id,
  input  wire logic [stq_pkg::FIELD_TIME_W-1:0] deadline,
  input  wire logic [stq_pkg::FIELD_TIME_W-1:0] now,
  // result item channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                expired,
  output logic [stq_pkg::ID_W-1:0]            expired_id,
  output logic [stq_pkg::STATUS_W-1:0]        status,
  output logic [CNT_W-1:0]                    occupancy
);

  localparam int IDX_W  = $clog2(DEPTH);
  // wide enough for both the port field and the stored time
  localparam int WIDE_W = (TIME_BITS > stq_pkg::FIELD_TIME_W) ? TIME_BITS
                                                               : stq_pkg::FIELD_TIME_W;

  // entry storage
  logic [TIME_BITS-1:0]        slot_deadline [DEPTH];
  logic [stq_pkg::ID_W-1:0]    slot_id       [DEPTH];
  logic [TIME_BITS-1:0]        rd_deadline;
  logic [stq_pkg::ID_W-1:0]    rd_id;

  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [TIME_BITS-1:0]        wr_deadline;
  logic [stq_pkg::ID_W-1:0]    wr_id;

  // sequencer state
  stq_pkg::state_t             state, state_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [CNT_W-1:0]            count, count_next;
  logic                        found, found_next;
  logic [stq_pkg::KIND_W-1:0]  op_kind, op_kind_next;
  logic [stq_pkg::ID_W-1:0]    op_id, op_id_next;
  logic [TIME_BITS-1:0]        op_when, op_when_next;
  logic [TIME_BITS-1:0]        op_now, op_now_next;

  // result being built
  logic                        res_expired, res_expired_next;
  logic [stq_pkg::ID_W-1:0]    res_id, res_id_next;
  logic [stq_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic                        out_valid_next;
  logic                        in_fire, out_fire, slot_free;
  logic                        hit, last;
  logic [WIDE_W-1:0]           deadline_wide, now_wide;

  assign in_stall  = (state != stq_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign slot_free = !out_valid || !out_stall;

  assign deadline_wide = WIDE_W'(deadline);
  assign now_wide      = WIDE_W'(now);

  // only delete and tick use these
  assign last = (CNT_W'(idx) == (count - CNT_W'(1)));
  always_comb begin
    if (found) begin
      hit = 1'b0;
    end else if (op_kind == stq_pkg::KIND_DEL) begin
      hit = (rd_id == op_id);
    end else begin
      hit = (idx == '0) && (op_now >= rd_deadline);
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    count_next       = count;
    found_next       = found;
    op_kind_next     = op_kind;
    op_id_next       = op_id;
    op_when_next     = op_when;
    op_now_next      = op_now;
    res_expired_next = res_expired;
    res_id_next      = res_id;
    res_status_next  = res_status;
    out_valid_next   = out_valid && !out_fire;
    wr_en            = 1'b0;
    wr_addr          = idx;
    wr_deadline      = rd_deadline;
    wr_id            = rd_id;

    case (state)
      stq_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_kind_next     = kind;
          op_id_next       = entry_id;
          op_when_next     = deadline_wide[TIME_BITS-1:0];
          op_now_next      = now_wide[TIME_BITS-1:0];
          found_next       = 1'b0;
          res_expired_next = 1'b0;
          res_id_next      = '0;
          res_status_next  = stq_pkg::STAT_OK;
          idx_next         = '0;
          case (kind)
            stq_pkg::KIND_ADD: begin
              if (count == CNT_W'(DEPTH)) begin
                res_status_next = stq_pkg::STAT_FULL;
                state_next      = stq_pkg::ST_DONE;
              end else if (count == '0) begin
                state_next = stq_pkg::ST_PUT;
              end else begin
                idx_next   = IDX_W'(count - CNT_W'(1));
                state_next = stq_pkg::ST_READ;
              end
            end
            stq_pkg::KIND_DEL: begin
              if (count == '0) begin
                res_status_next = stq_pkg::STAT_NOT_FOUND;
                state_next      = stq_pkg::ST_DONE;
              end else begin
                state_next = stq_pkg::ST_READ;
              end
            end
            stq_pkg::KIND_TICK: begin
              state_next = (count == '0) ? stq_pkg::ST_DONE : stq_pkg::ST_READ;
            end
            default: begin
              state_next = stq_pkg::ST_DONE;
            end
          endcase
        end
      end

      stq_pkg::ST_READ: begin
        state_next = stq_pkg::ST_EVAL;
      end

      stq_pkg::ST_EVAL: begin
        if (op_kind == stq_pkg::KIND_ADD) begin
          if (rd_deadline >= op_when) begin
            // shift this entry up one place
            wr_en   = 1'b1;
            wr_addr = idx + IDX_W'(1);
            if (idx == '0) begin
              state_next = stq_pkg::ST_PUT;
            end else begin
              idx_next   = idx - IDX_W'(1);
              state_next = stq_pkg::ST_READ;
            end
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = stq_pkg::ST_PUT;
          end
        end else begin
          if (found) begin
            // pull this entry down over the removed one
            wr_en   = 1'b1;
            wr_addr = idx - IDX_W'(1);
          end
          if (hit) begin
            found_next = 1'b1;
            if (op_kind == stq_pkg::KIND_TICK) begin
              res_expired_next = 1'b1;
              res_id_next      = rd_id;
            end
          end
          if (last) begin
            if (found || hit) begin
              count_next = count - CNT_W'(1);
            end else if (op_kind == stq_pkg::KIND_DEL) begin
              res_status_next = stq_pkg::STAT_NOT_FOUND;
            end
            state_next = stq_pkg::ST_DONE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = stq_pkg::ST_READ;
          end
        end
      end

      stq_pkg::ST_PUT: begin
        wr_en       = 1'b1;
        wr_addr     = idx;
        wr_deadline = op_when;
        wr_id       = op_id;
        count_next  = count + CNT_W'(1);
        state_next  = stq_pkg::ST_DONE;
      end

      stq_pkg::ST_DONE: begin
        // wait until the output register is free
        if (slot_free) begin
          out_valid_next = 1'b1;
          state_next     = stq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = stq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stq_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    found       <= found_next;
    op_kind     <= op_kind_next;
    op_id       <= op_id_next;
    op_when     <= op_when_next;
    op_now      <= op_now_next;
    res_expired <= res_expired_next;
    res_id      <= res_id_next;
    res_status  <= res_status_next;
    if (state == stq_pkg::ST_DONE && slot_free) begin
      expired    <= res_expired;
      expired_id <= res_id;
      status     <= res_status;
      occupancy  <= count;
    end
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_deadline[wr_addr] <= wr_deadline;
      slot_id[wr_addr]       <= wr_id;
    end
    rd_deadline <= slot_deadline[idx];
    rd_id       <= slot_id[idx];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("pending count above depth");

  a_count_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    !(state == stq_pkg::ST_EVAL || state == stq_pkg::ST_PUT) |=> $stable(count))
    else $error("pending count changed outside eval or put");

  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == stq_pkg::STAT_FULL) |-> occupancy == CNT_W'(DEPTH))
    else $error("full status with queue not full");

  a_expired_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && expired) |-> status == stq_pkg::STAT_OK)
    else $error("expired item carries error status");

endmodule

`default_nettype wire
